### src/psgs_pkg.sv
package psgs_pkg;

    localparam int DEF_MAX_HALF    = 10;
    localparam int DEF_COORD_WIDTH = 12;

    localparam int SEL_W     = 2;
    localparam int TAP_W     = 12;
    localparam int TAP_COUNT = 11;
    localparam int NORM_W    = 13;
    localparam int SEEN_W    = 5;
    localparam int STEP_W    = 4;

    localparam logic [SEL_W-1:0]  SIGMA_RESET = 2'd1;
    localparam logic [SEEN_W-1:0] SEEN_MAX    = 5'd31;

    localparam logic [NORM_W-1:0] NORM_S1 = 13'd7471;
    localparam logic [NORM_W-1:0] NORM_S2 = 13'd2289;
    localparam logic [NORM_W-1:0] NORM_S3 = 13'd1945;

    // index 0 is the center tap
    localparam logic [TAP_COUNT-1:0][TAP_W-1:0] TAPS_S1 = {
        12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
        12'd1, 12'd33, 12'd403, 12'd1808, 12'd2981
    };
    localparam logic [TAP_COUNT-1:0][TAP_W-1:0] TAPS_S2 = {
        12'd0, 12'd0, 12'd0, 12'd1, 12'd5, 12'd20,
        12'd62, 12'd148, 12'd277, 12'd403, 12'd457
    };
    localparam logic [TAP_COUNT-1:0][TAP_W-1:0] TAPS_S3 = {
        12'd1, 12'd3, 12'd7, 12'd17, 12'd35, 12'd65,
        12'd106, 12'd157, 12'd207, 12'd245, 12'd259
    };

    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
    } div_ctrl_t;

    function automatic logic [TAP_W-1:0] half_tap(input logic [SEL_W-1:0] sel,
                                                   input logic [STEP_W-1:0] d);
        logic [TAP_W-1:0] r;
        r = '0;
        if (d < STEP_W'(TAP_COUNT)) begin
            case (sel)
                2'd0: r = TAPS_S1[d];
                2'd1: r = TAPS_S2[d];
                2'd2: r = TAPS_S3[d];
                default: r = '0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [NORM_W-1:0] norm_of(input logic [SEL_W-1:0] sel);
        logic [NORM_W-1:0] r;
        case (sel)
            2'd0: r = NORM_S1;
            2'd1: r = NORM_S2;
            2'd2: r = NORM_S3;
            default: r = NORM_S1;
        endcase
        return r;
    endfunction

    // half width 3*sigma+1 for sigma = sel+1
    function automatic logic [STEP_W-1:0] half_len(input logic [SEL_W-1:0] sel);
        logic [STEP_W-1:0] r;
        case (sel)
            2'd0: r = 4'd4;
            2'd1: r = 4'd7;
            2'd2: r = 4'd10;
            default: r = 4'd4;
        endcase
        return r;
    endfunction

endpackage

### src/psgs_round_div.sv
module psgs_round_div #(
    parameter int COORD_WIDTH = psgs_pkg::DEF_COORD_WIDTH
) (
    input  logic                                   aclk,
    input  psgs_pkg::div_ctrl_t                    ctrl,
    input  logic [psgs_pkg::SEL_W-1:0]             sel_in,
    input  logic [COORD_WIDTH+psgs_pkg::NORM_W:0]  num_in,
    output logic [COORD_WIDTH-1:0]                 q_out
);

    localparam int NUM_W   = COORD_WIDTH + psgs_pkg::NORM_W + 1;
    localparam int RECIP_W = NUM_W - 11;
    localparam int PA_W    = NUM_W + RECIP_W;
    localparam int DEN_W   = psgs_pkg::NORM_W + 1;
    localparam int PB_W    = COORD_WIDTH + DEN_W;

    localparam longint unsigned RECIP_S1 =
        (64'd1 << NUM_W) / (64'd2 * 64'(psgs_pkg::NORM_S1));
    localparam longint unsigned RECIP_S2 =
        (64'd1 << NUM_W) / (64'd2 * 64'(psgs_pkg::NORM_S2));
    localparam longint unsigned RECIP_S3 =
        (64'd1 << NUM_W) / (64'd2 * 64'(psgs_pkg::NORM_S3));

    logic [RECIP_W-1:0]           recip;
    logic [PA_W-1:0]              prod_a;
    logic [NUM_W-1:0]             num_a_reg;
    logic [psgs_pkg::SEL_W-1:0]   sel_a_reg;
    logic [COORD_WIDTH-1:0]       est_a_reg;
    logic [NUM_W-1:0]             num_b_reg;
    logic [psgs_pkg::SEL_W-1:0]   sel_b_reg;
    logic [COORD_WIDTH-1:0]       est_b_reg;
    logic [PB_W-1:0]              back_b_reg;
    logic [DEN_W-1:0]             den_a;
    logic [DEN_W-1:0]             den_b;
    logic [NUM_W-1:0]             rem_b;
    logic [COORD_WIDTH-1:0]       q_reg;

    always_comb begin
        case (sel_in)
            2'd0: recip = RECIP_W'(RECIP_S1);
            2'd1: recip = RECIP_W'(RECIP_S2);
            2'd2: recip = RECIP_W'(RECIP_S3);
            default: recip = RECIP_W'(RECIP_S1);
        endcase
        prod_a = PA_W'(num_in) * PA_W'(recip);
        den_a  = {psgs_pkg::norm_of(sel_a_reg), 1'b0};
        den_b  = {psgs_pkg::norm_of(sel_b_reg), 1'b0};
        rem_b  = num_b_reg - NUM_W'(back_b_reg);
    end

    // estimate is the quotient or one below it
    always_ff @(posedge aclk) begin
        if (ctrl.en_a) begin
            num_a_reg <= num_in;
            sel_a_reg <= sel_in;
            est_a_reg <= prod_a[NUM_W +: COORD_WIDTH];
        end
        if (ctrl.en_b) begin
            num_b_reg  <= num_a_reg;
            sel_b_reg  <= sel_a_reg;
            est_b_reg  <= est_a_reg;
            back_b_reg <= PB_W'(est_a_reg) * PB_W'(den_a);
        end
        if (ctrl.en_c) begin
            q_reg <= (rem_b >= NUM_W'(den_b)) ? est_b_reg + 1'b1 : est_b_reg;
        end
    end

    assign q_out = q_reg;

endmodule

### src/point_sequence_gauss_smoother.sv
// channel  direction  handshake                 payload
// cfg      in         cfg_valid / cfg_ready     cfg_data = kernel_sigma
// s_       in         s_tvalid / s_tready       s_tdata = in_x, in_y; s_tlast = in_last
// m_       out        m_tvalid / m_tready       m_tdata = out_x, out_y; m_tlast = out_last
//
// points are pipelined: a new point can be taken while earlier ones are in flight; the
// last point is replayed into the window L times (L = 4, 7 or 10) to flush the tail,
// with s_tready low meanwhile; results pass through the window, products, group sums,
// numerator and three divider stages; each stage holds only when full
// reset is synchronous and clears the sequence count, the flush and all stage valids
// a stalled m_ side fills the empty stages before s_tready drops
module point_sequence_gauss_smoother #(
    parameter int MAX_HALF    = psgs_pkg::DEF_MAX_HALF,
    parameter int COORD_WIDTH = psgs_pkg::DEF_COORD_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [psgs_pkg::SEL_W-1:0]           cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,   // in_x, in_y
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]   m_tdata,   // out_x, out_y
    output logic                                 m_tlast
);

    localparam int DATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int WIN     = 2 * MAX_HALF + 1;
    localparam int NG      = (WIN + 3) / 4;
    localparam int TAP_W   = psgs_pkg::TAP_W;
    localparam int PROD_W  = TAP_W + COORD_WIDTH;
    localparam int GRP_W   = PROD_W + 2;
    localparam int SUM_W   = COORD_WIDTH + psgs_pkg::NORM_W;
    localparam int NUM_W   = SUM_W + 1;
    localparam int SEL_W   = psgs_pkg::SEL_W;
    localparam int SEEN_W  = psgs_pkg::SEEN_W;
    localparam int STEP_W  = psgs_pkg::STEP_W;
    localparam int NSTAGE  = 7;

    localparam int LIMIT_RAW = (MAX_HALF - 1) / 3;
    localparam int LIMIT_HI  = (LIMIT_RAW > 3) ? 3 : LIMIT_RAW;
    localparam int LIMIT     = (LIMIT_HI < 1) ? 1 : LIMIT_HI;
    localparam logic [SEL_W-1:0] SIGMA_LIMIT = SEL_W'(LIMIT);

    logic [SEL_W-1:0]        kernel_sigma_reg;
    logic [SEL_W-1:0]        active_sel_reg;
    logic [SEL_W-1:0]        active_sel_next;
    logic [SEEN_W-1:0]       seen_reg;
    logic [SEEN_W-1:0]       seen_next;
    logic                    flushing_reg;
    logic                    flushing_next;
    logic [STEP_W-1:0]       step_reg;
    logic [STEP_W-1:0]       step_next;
    logic [NSTAGE-1:0]       valid_reg;
    logic                    valid0_next;
    logic                    last0_reg;
    logic                    last0_next;
    logic [NSTAGE-1:0]       rdy;
    logic [NSTAGE-1:0]       load;

    logic [COORD_WIDTH-1:0]  win_x_reg [WIN];
    logic [COORD_WIDTH-1:0]  win_y_reg [WIN];
    logic                    win_fill;
    logic                    win_shift;
    logic [COORD_WIDTH-1:0]  shift_x;
    logic [COORD_WIDTH-1:0]  shift_y;

    logic [COORD_WIDTH-1:0]  in_x;
    logic [COORD_WIDTH-1:0]  in_y;
    logic                    in_fire;
    logic                    flush_fire;
    logic [SEL_W-1:0]        sigma_clamped;
    logic [SEL_W-1:0]        eff_sel;
    logic [SEL_W-1:0]        cur_sel;
    logic [SEEN_W-1:0]       seen_inc;
    logic [SEEN_W:0]         seen_plus_step;
    logic [STEP_W-1:0]       cur_len;

    logic [TAP_W-1:0]        tap [WIN];
    logic [PROD_W-1:0]       prod_x_reg [WIN];
    logic [PROD_W-1:0]       prod_y_reg [WIN];
    logic [GRP_W-1:0]        grp_x_c [NG];
    logic [GRP_W-1:0]        grp_y_c [NG];
    logic [GRP_W-1:0]        grp_x_reg [NG];
    logic [GRP_W-1:0]        grp_y_reg [NG];
    logic [SUM_W-1:0]        sum_x;
    logic [SUM_W-1:0]        sum_y;
    logic [NUM_W-1:0]        num_x_reg;
    logic [NUM_W-1:0]        num_y_reg;
    logic [SEL_W-1:0]        sel1_reg;
    logic [SEL_W-1:0]        sel2_reg;
    logic [SEL_W-1:0]        sel3_reg;
    logic [NSTAGE-1:1]       last_reg;

    psgs_pkg::div_ctrl_t     div_ctrl;
    logic [COORD_WIDTH-1:0]  out_x;
    logic [COORD_WIDTH-1:0]  out_y;

    assign in_x = s_tdata[COORD_WIDTH-1:0];
    assign in_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign cfg_ready = 1'b1;

    // stage handshake, stage 0 is the window
    always_comb begin
        rdy[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        load[0] = 1'b0;
        for (int k = 1; k < NSTAGE; k++) begin
            load[k] = rdy[k] && valid_reg[k-1];
        end
    end

    always_comb begin
        sigma_clamped = (kernel_sigma_reg == '0) ? SEL_W'(1) : kernel_sigma_reg;
        if (sigma_clamped > SIGMA_LIMIT) begin
            sigma_clamped = SIGMA_LIMIT;
        end
        eff_sel  = sigma_clamped - 1'b1;
        cur_sel  = (seen_reg == '0) ? eff_sel : active_sel_reg;
        seen_inc = (seen_reg == psgs_pkg::SEEN_MAX) ? seen_reg : seen_reg + 1'b1;

        s_tready   = rdy[0] && !flushing_reg;
        in_fire    = s_tvalid && s_tready;
        flush_fire = flushing_reg && rdy[0];

        active_sel_next = active_sel_reg;
        seen_next       = seen_reg;
        flushing_next   = flushing_reg;
        step_next       = step_reg;
        valid0_next     = valid_reg[0] && !rdy[1];
        last0_next      = last0_reg;
        win_fill        = 1'b0;
        win_shift       = 1'b0;
        shift_x         = win_x_reg[0];
        shift_y         = win_y_reg[0];
        cur_len         = psgs_pkg::half_len(cur_sel);
        seen_plus_step  = {1'b0, seen_reg} + (SEEN_W+1)'(step_reg);

        if (in_fire) begin
            active_sel_next = cur_sel;
            seen_next       = seen_inc;
            win_fill        = (seen_reg == '0);
            win_shift       = (seen_reg != '0);
            shift_x         = in_x;
            shift_y         = in_y;
            valid0_next     = ({1'b0, seen_inc} > (SEEN_W+1)'(cur_len));
            last0_next      = 1'b0;
            if (s_tlast) begin
                flushing_next = 1'b1;
                step_next     = STEP_W'(1);
            end
        end else if (flush_fire) begin
            // replay the last point into the window
            win_shift   = 1'b1;
            valid0_next = (seen_plus_step > (SEEN_W+1)'(cur_len));
            last0_next  = (step_reg == cur_len);
            step_next   = step_reg + 1'b1;
            if (step_reg == cur_len) begin
                flushing_next = 1'b0;
                seen_next     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_sigma_reg <= psgs_pkg::SIGMA_RESET;
            active_sel_reg   <= '0;
            seen_reg         <= '0;
            flushing_reg     <= 1'b0;
            step_reg         <= '0;
            valid_reg        <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                kernel_sigma_reg <= cfg_data;
            end
            active_sel_reg <= active_sel_next;
            seen_reg       <= seen_next;
            flushing_reg   <= flushing_next;
            step_reg       <= step_next;
            valid_reg[0]   <= valid0_next;
            for (int k = 1; k < NSTAGE; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        last0_reg <= last0_next;
        if (win_fill) begin
            for (int i = 0; i < WIN; i++) begin
                win_x_reg[i] <= in_x;
                win_y_reg[i] <= in_y;
            end
        end else if (win_shift) begin
            for (int i = 1; i < WIN; i++) begin
                win_x_reg[i] <= win_x_reg[i-1];
                win_y_reg[i] <= win_y_reg[i-1];
            end
            win_x_reg[0] <= shift_x;
            win_y_reg[0] <= shift_y;
        end
    end

    // taps per window slot, centered on slot L
    always_comb begin
        int l;
        int d;
        l = int'(psgs_pkg::half_len(active_sel_reg));
        for (int i = 0; i < WIN; i++) begin
            d = (i > l) ? i - l : l - i;
            tap[i] = (d < psgs_pkg::TAP_COUNT) ?
                     psgs_pkg::half_tap(active_sel_reg, STEP_W'(d)) : '0;
        end
    end

    always_comb begin
        int idx;
        for (int g = 0; g < NG; g++) begin
            grp_x_c[g] = '0;
            grp_y_c[g] = '0;
            for (int j = 0; j < 4; j++) begin
                idx = 4 * g + j;
                if (idx < WIN) begin
                    grp_x_c[g] = grp_x_c[g] + GRP_W'(prod_x_reg[idx]);
                    grp_y_c[g] = grp_y_c[g] + GRP_W'(prod_y_reg[idx]);
                end
            end
        end
        sum_x = '0;
        sum_y = '0;
        for (int g = 0; g < NG; g++) begin
            sum_x = sum_x + SUM_W'(grp_x_reg[g]);
            sum_y = sum_y + SUM_W'(grp_y_reg[g]);
        end
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            for (int i = 0; i < WIN; i++) begin
                prod_x_reg[i] <= PROD_W'(tap[i]) * PROD_W'(win_x_reg[i]);
                prod_y_reg[i] <= PROD_W'(tap[i]) * PROD_W'(win_y_reg[i]);
            end
            sel1_reg    <= active_sel_reg;
            last_reg[1] <= last0_reg;
        end
        if (load[2]) begin
            for (int g = 0; g < NG; g++) begin
                grp_x_reg[g] <= grp_x_c[g];
                grp_y_reg[g] <= grp_y_c[g];
            end
            sel2_reg    <= sel1_reg;
            last_reg[2] <= last_reg[1];
        end
        if (load[3]) begin
            num_x_reg   <= {sum_x, 1'b0} + NUM_W'(psgs_pkg::norm_of(sel2_reg));
            num_y_reg   <= {sum_y, 1'b0} + NUM_W'(psgs_pkg::norm_of(sel2_reg));
            sel3_reg    <= sel2_reg;
            last_reg[3] <= last_reg[2];
        end
        for (int k = 4; k < NSTAGE; k++) begin
            if (load[k]) begin
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    assign div_ctrl.en_a = load[4];
    assign div_ctrl.en_b = load[5];
    assign div_ctrl.en_c = load[6];

    psgs_round_div #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_div_x (
        .aclk   (aclk),
        .ctrl   (div_ctrl),
        .sel_in (sel3_reg),
        .num_in (num_x_reg),
        .q_out  (out_x)
    );

    psgs_round_div #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_div_y (
        .aclk   (aclk),
        .ctrl   (div_ctrl),
        .sel_in (sel3_reg),
        .num_in (num_y_reg),
        .q_out  (out_y)
    );

    always_comb begin
        m_tdata = '0;
        m_tdata[COORD_WIDTH-1:0]             = out_x;
        m_tdata[2*COORD_WIDTH-1:COORD_WIDTH] = out_y;
    end

    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tlast  = last_reg[NSTAGE-1];

endmodule

### test/tb_top.sv
module tb_top;

    localparam int CW      = psgs_pkg::DEF_COORD_WIDTH;
    localparam int DATA_W  = 2 * CW;
    localparam int HIST_N  = 2 * psgs_pkg::DEF_MAX_HALF + 1;
    localparam int SEEN_TOP = 31;
    localparam int FLUSH_WAIT = 20;
    localparam int LONG_HOLD  = 80;
    localparam int ITEM_GOAL  = 220;
    localparam int QUIET_FROM = 190;

    typedef struct packed {
        logic          last;
        logic [CW-1:0] y;
        logic [CW-1:0] x;
    } smooth_pt_t;

    typedef struct packed {
        int            cfg;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
        bit            typed;
        logic [CW-1:0] ex;
        logic [CW-1:0] ey;
    } dir_row_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [psgs_pkg::SEL_W-1:0]   cfg_data;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [DATA_W-1:0]            s_tdata;   // in_x, in_y
    logic                         s_tlast;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [DATA_W-1:0]            m_tdata;   // out_x, out_y
    logic                         m_tlast;

    point_sequence_gauss_smoother u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // half kernels, center tap first, one row per sigma
    int unsigned gauss_taps [3][11] = '{
        '{2981, 1808, 403, 33, 1, 0, 0, 0, 0, 0, 0},
        '{457, 403, 277, 148, 62, 20, 5, 1, 0, 0, 0},
        '{259, 245, 207, 157, 106, 65, 35, 17, 7, 3, 1}
    };
    int unsigned gauss_norm [3] = '{7471, 2289, 1945};

    logic [CW-1:0] hist_x [HIST_N];
    logic [CW-1:0] hist_y [HIST_N];
    int            seq_len;
    logic [1:0]    cfg_sigma;
    int            run_sigma;

    smooth_pt_t smoothed_q [$];

    int  err_count;
    int  points_sent;
    int  seqs_sent;
    int  results_seen;
    int  sigma_writes;
    bit  quiet;
    bit  hold_req;
    bit  rx_stall_on;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_count++;
    endtask

    task automatic add_expected(input smooth_pt_t p);
        smoothed_q.insert(smoothed_q.size(), p);
    endtask

    task automatic shift_point(input logic [CW-1:0] px, input logic [CW-1:0] py);
        for (int i = HIST_N - 1; i > 0; i--) begin
            hist_x[i] = hist_x[i-1];
            hist_y[i] = hist_y[i-1];
        end
        hist_x[0] = px;
        hist_y[0] = py;
    endtask

    function automatic smooth_pt_t filter_at(input int sel, input int hw, input logic lst);
        longint unsigned sx, sy, nrm;
        smooth_pt_t r;
        int d;
        sx = 0;
        sy = 0;
        nrm = gauss_norm[sel];
        for (int i = 0; i <= 2 * hw; i++) begin
            d = (i > hw) ? (i - hw) : (hw - i);
            sx += longint'(gauss_taps[sel][d]) * hist_x[i];
            sy += longint'(gauss_taps[sel][d]) * hist_y[i];
        end
        r.x = CW'((2 * sx + nrm) / (2 * nrm));
        r.y = CW'((2 * sy + nrm) / (2 * nrm));
        r.last = lst;
        return r;
    endfunction

    // queues every smoothed point that one accepted input releases
    task automatic smooth_point(input logic [CW-1:0] px, input logic [CW-1:0] py,
                                input logic plast);
        int sel;
        int hw;
        if (seq_len == 0) begin
            run_sigma = (cfg_sigma == 2'd0) ? 1 : int'(cfg_sigma);
            for (int i = 0; i < HIST_N; i++) begin
                hist_x[i] = px;
                hist_y[i] = py;
            end
        end else begin
            shift_point(px, py);
        end
        if (seq_len < SEEN_TOP) seq_len++;
        sel = run_sigma - 1;
        hw = 3 * run_sigma + 1;
        if (!plast) begin
            if (seq_len > hw) add_expected(filter_at(sel, hw, 1'b0));
        end else begin
            for (int k = 0; k <= hw; k++) begin
                if (k > 0) shift_point(px, py);
                if (seq_len + k >= hw + 1) add_expected(filter_at(sel, hw, k == hw));
            end
            seq_len = 0;
        end
    endtask

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_point(input logic [CW-1:0] px, input logic [CW-1:0] py,
                              input logic plast);
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        s_tlast  <= plast;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        smooth_point(px, py, plast);
        points_sent++;
        if (plast) seqs_sent++;
        @(negedge aclk);
    endtask

    task automatic write_sigma(input logic [1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_sigma = v;
        sigma_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (smoothed_q.size() != 0) @(negedge aclk);
        repeat (FLUSH_WAIT) @(negedge aclk);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
    endtask

    function automatic logic [CW-1:0] next_coord(input int mode, input int prev);
        int v;
        case (mode)
            0: begin
                v = prev + int'($urandom_range(0, 96)) - 48;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
            end
            1: v = $urandom_range(0, 4095);
            default: v = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095) :
                         ($urandom_range(0, 1) == 0) ? 0 : 4095;
        endcase
        return CW'(v);
    endfunction

    dir_row_t dir_rows [0:22] = '{
        '{-1, 12'd0,    12'd0,    1'b1, 1'b1, 12'd0,    12'd0},
        '{-1, 12'd4095, 12'd4095, 1'b1, 1'b1, 12'd4095, 12'd4095},
        '{-1, 12'd2730, 12'd1365, 1'b1, 1'b1, 12'd2730, 12'd1365},
        '{-1, 12'd1365, 12'd2730, 1'b1, 1'b1, 12'd1365, 12'd2730},
        '{-1, 12'd0,    12'd4095, 1'b0, 1'b0, 12'd0,    12'd0},
        '{-1, 12'd4095, 12'd0,    1'b0, 1'b0, 12'd0,    12'd0},
        '{-1, 12'd0,    12'd4095, 1'b0, 1'b0, 12'd0,    12'd0},
        '{-1, 12'd4095, 12'd0,    1'b0, 1'b0, 12'd0,    12'd0},
        '{-1, 12'd0,    12'd4095, 1'b0, 1'b0, 12'd0,    12'd0},
        '{-1, 12'd4095, 12'd0,    1'b1, 1'b0, 12'd0,    12'd0},
        '{0,  12'd1234, 12'd3000, 1'b1, 1'b1, 12'd1234, 12'd3000},
        '{-1, 12'd100,  12'd200,  1'b0, 1'b0, 12'd0,    12'd0},
        '{-1, 12'd300,  12'd400,  1'b0, 1'b0, 12'd0,    12'd0},
        '{-1, 12'd4095, 12'd4095, 1'b1, 1'b0, 12'd0,    12'd0},
        '{2,  12'd4095, 12'd0,    1'b1, 1'b1, 12'd4095, 12'd0},
        '{-1, 12'd10,   12'd4000, 1'b0, 1'b0, 12'd0,    12'd0},
        '{-1, 12'd4095, 12'd17,   1'b0, 1'b0, 12'd0,    12'd0},
        '{-1, 12'd2048, 12'd2047, 1'b0, 1'b0, 12'd0,    12'd0},
        '{-1, 12'd0,    12'd4095, 1'b0, 1'b0, 12'd0,    12'd0},
        '{-1, 12'd777,  12'd3333, 1'b1, 1'b0, 12'd0,    12'd0},
        '{3,  12'd0,    12'd4095, 1'b1, 1'b1, 12'd0,    12'd4095},
        '{-1, 12'd4095, 12'd4095, 1'b0, 1'b0, 12'd0,    12'd0},
        '{-1, 12'd0,    12'd0,    1'b1, 1'b0, 12'd0,    12'd0}
    };

    // result side
    initial begin
        m_tready = 1'b0;
        rx_stall_on = 1'b1;
        forever begin
            if ($urandom_range(0, 63) == 0) rx_stall_on = !rx_stall_on;
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (!quiet && rx_stall_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        smooth_pt_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (smoothed_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer x=%0d y=%0d last=%0b",
                                          m_tdata[CW-1:0], m_tdata[DATA_W-1:CW], m_tlast));
            end else begin
                want = smoothed_q.pop_front();
                if (m_tdata[CW-1:0] !== want.x)
                    report_mismatch($sformatf("out_x %0d, want %0d",
                                              m_tdata[CW-1:0], want.x));
                if (m_tdata[DATA_W-1:CW] !== want.y)
                    report_mismatch($sformatf("out_y %0d, want %0d",
                                              m_tdata[DATA_W-1:CW], want.y));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("out_last %0b, want %0b", m_tlast, want.last));
            end
        end
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // point side
    initial begin
        int n0;
        int len;
        int mode;
        int cx;
        int cy;
        bit mid_write;
        bit first_rand;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        err_count = 0;
        points_sent = 0;
        seqs_sent = 0;
        results_seen = 0;
        sigma_writes = 0;
        cfg_sigma = psgs_pkg::SIGMA_RESET;
        run_sigma = 1;
        seq_len = 0;
        for (int i = 0; i < HIST_N; i++) begin
            hist_x[i] = '0;
            hist_y[i] = '0;
        end
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].cfg >= 0 || dir_rows[r].typed) begin
                drain_results();
            end
            if (dir_rows[r].cfg >= 0) begin
                write_sigma(dir_rows[r].cfg[1:0]);
            end
            sender_gap();
            n0 = smoothed_q.size();
            send_point(dir_rows[r].x, dir_rows[r].y, dir_rows[r].last);
            if (dir_rows[r].typed) begin
                while (smoothed_q.size() > n0) void'(smoothed_q.pop_back());
                add_expected(smooth_pt_t'({1'b1, dir_rows[r].ey, dir_rows[r].ex}));
            end
        end

        first_rand = 1'b1;
        while (points_sent < ITEM_GOAL) begin
            if (points_sent >= QUIET_FROM) quiet = 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                drain_results();
                write_sigma(2'($urandom_range(0, 3)));
            end
            if (first_rand) begin
                len = 30;
                hold_req = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(32, 40);
            end else begin
                len = $urandom_range(1, 14);
            end
            mode = $urandom_range(0, 2);
            mid_write = !quiet && (len > 1) && ($urandom_range(0, 5) == 0);
            cx = $urandom_range(0, 4095);
            cy = $urandom_range(0, 4095);
            for (int p = 0; p < len; p++) begin
                cx = next_coord(mode, cx);
                cy = next_coord(mode, cy);
                if (!first_rand) sender_gap();
                send_point(CW'(cx), CW'(cy), p == len - 1);
                // new sigma must wait for the next sequence
                if (mid_write && p == 0) begin
                    drain_results();
                    write_sigma(2'($urandom_range(0, 3)));
                end
            end
            if (first_rand) begin
                first_rand = 1'b0;
                drain_results();
            end
        end

        s_tvalid <= 1'b0;
        while (smoothed_q.size() != 0) @(posedge aclk);
        repeat (FLUSH_WAIT) @(posedge aclk);

        $display("sent %0d points in %0d sequences, checked %0d smoothed points",
                 points_sent, seqs_sent, results_seen);
        $display("%0d sigma writes incl. zero and mid-sequence, one long output hold",
                 sigma_writes);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
